### design/fourier_series_evaluator_assert.svh
// Assertion macros used by the checker of the Fourier series evaluator.
// Needs clk_i and rst_ni to be visible where a macro is used.
`ifndef FOURIER_SERIES_EVALUATOR_ASSERT_SVH
`define FOURIER_SERIES_EVALUATOR_ASSERT_SVH

// Checked at every rising edge outside reset.
`define FSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define FSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/fse_pkg.sv
// Package of the Fourier series evaluator: payload and control types, opcodes,
// register indexes and the elaboration-time quarter-wave sine generator.
`timescale 1ns / 1ps

package fse_pkg;

  localparam int unsigned MAX_DEGREE_DEF      = 64;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned COEF_WIDTH_DEF      = 32;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // Divisors (2n)(2n+1) of the Taylor series terms.
  localparam longint unsigned TaylorDiv [1:10] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef enum logic [1:0] {
    OP_WR_COS = 2'd0,
    OP_WR_SIN = 2'd1,
    OP_EVAL   = 2'd2,
    OP_READ   = 2'd3
  } fse_op_e;

  typedef enum logic {
    CFG_DEGREE     = 1'b0,
    CFG_INV_PERIOD = 1'b1
  } fse_cfg_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [6:0]         index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point;
  } fse_in_t;

  typedef struct packed {
    logic signed [31:0] series_value;
    logic signed [31:0] cos_coef;
    logic signed [31:0] sin_coef;
    logic               bad_index;
  } fse_out_t;

  typedef struct packed {
    logic item_load;
    logic wr_en;
    logic rd_item;
    logic phase_calc;
    logic acc_init;
    logic fetch;
    logic mul_en;
    logic mul_sin;
    logic acc_add;
    logic res_load;
    logic res_eval;
  } fse_cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       d_zero;
    logic       more;
    logic       out_free;
  } fse_sts_t;

  // Quarter-wave sine in Q1.15 magnitude, evaluated only at elaboration.
  function automatic logic [14:0] quarter_sine(int unsigned q, int unsigned bits);
    longint unsigned qq;
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    qq    = q;
    theta = (qq * TWO_PI_Q30) >> bits;
    t2    = (theta * theta) >> 30;
    term  = theta;
    sum   = longint'(theta);
    for (int n = 1; n <= 10; n++) begin
      term = (term * t2) >> 30;
      term = term / TaylorDiv[n];
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = sum;
    v = (v * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return 15'(v);
  endfunction

endpackage

### design/fse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fse_ram #(
  parameter int unsigned DataWidth = 32,
  parameter int unsigned Depth     = 64,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/fse_ctrl.sv
// Sequencing state machine of the Fourier series evaluator.
// Depends on fse_pkg for the command and status structs and the opcodes.
`timescale 1ns / 1ps

module fse_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fse_pkg::fse_sts_t sts_i,
  output fse_pkg::fse_cmd_t cmd_o
);

  import fse_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_WRITE     = 4'd1;
  localparam logic [3:0] S_READ      = 4'd2;
  localparam logic [3:0] S_READ_WAIT = 4'd3;
  localparam logic [3:0] S_PHASE     = 4'd4;
  localparam logic [3:0] S_INIT      = 4'd5;
  localparam logic [3:0] S_FETCH     = 4'd6;
  localparam logic [3:0] S_TERM_C    = 4'd7;
  localparam logic [3:0] S_TERM_S    = 4'd8;
  localparam logic [3:0] S_DRAIN     = 4'd9;
  localparam logic [3:0] S_RESULT    = 4'd10;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.item_load = 1'b1;
          unique case (sts_i.in_op)
            OP_WR_COS, OP_WR_SIN: state_d = S_WRITE;
            OP_EVAL:              state_d = S_PHASE;
            OP_READ:              state_d = S_READ;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_d     = S_IDLE;
      end
      S_READ: begin
        cmd_o.rd_item = 1'b1;
        state_d       = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_PHASE: begin
        cmd_o.phase_calc = 1'b1;
        state_d          = S_INIT;
      end
      S_INIT: begin
        cmd_o.acc_init = 1'b1;
        state_d        = sts_i.d_zero ? S_RESULT : S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_TERM_C;
      end
      S_TERM_C: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.acc_add = 1'b1;
        state_d       = S_TERM_S;
      end
      S_TERM_S: begin
        // The next harmonic is fetched while the sine term is multiplied.
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sin = 1'b1;
        cmd_o.acc_add = 1'b1;
        if (sts_i.more) begin
          cmd_o.fetch = 1'b1;
          state_d     = S_TERM_C;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_eval = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/fse_dp.sv
// Datapath of the Fourier series evaluator: configuration registers, coefficient
// RAMs with valid bits, sine table, phase unit, shared MAC and output register.
// Depends on fse_pkg and fse_ram.
`timescale 1ns / 1ps

module fse_dp #(
  parameter int unsigned MaxDegree     = fse_pkg::MAX_DEGREE_DEF,
  parameter int unsigned SineTableBits = fse_pkg::SINE_TABLE_BITS_DEF,
  parameter int unsigned CoefWidth     = fse_pkg::COEF_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fse_pkg::fse_in_t  in_data_i,
  input  fse_pkg::fse_cmd_t cmd_i,
  output fse_pkg::fse_sts_t sts_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fse_pkg::fse_out_t out_data_o
);

  import fse_pkg::*;

  localparam int unsigned AddrW   = $clog2(MaxDegree + 1);
  localparam int unsigned SinAW   = (MaxDegree > 1) ? $clog2(MaxDegree) : 1;
  localparam int unsigned Quarter = 1 << (SineTableBits - 2);
  localparam int unsigned QW      = SineTableBits - 1;
  localparam int unsigned ProdW   = CoefWidth + 16;
  localparam longint      CoefHi  = (longint'(1) <<< (CoefWidth - 1)) - 1;
  localparam longint      CoefLo  = -CoefHi - 1;

  // Quarter-wave table, entries 0..Quarter.
  logic [14:0] qtab [Quarter + 1];

  for (genvar g = 0; g <= Quarter; g++) begin : g_qtab
    localparam logic [14:0] QVal = quarter_sine(g, SineTableBits);
    assign qtab[g] = QVal;
  end

  function automatic logic signed [15:0] rom_val(logic [SineTableBits-1:0] i);
    logic [1:0]    quad;
    logic [QW-1:0] r;
    logic [QW-1:0] ri;
    logic [14:0]   m;
    quad = i[SineTableBits-1 -: 2];
    r    = QW'(i[SineTableBits-3:0]);
    ri   = quad[0] ? (QW'(Quarter) - r) : r;
    m    = qtab[ri];
    return quad[1] ? -signed'({1'b0, m}) : signed'({1'b0, m});
  endfunction

  logic [6:0]  degree_q;
  logic [31:0] inv_period_q;
  fse_in_t     item_q;

  logic [MaxDegree:0]   cos_vld_q;
  logic [MaxDegree-1:0] sin_vld_q;
  logic                 cos_vrd_q, sin_vrd_q;

  logic                        cos_we, sin_we, cos_re, sin_re;
  logic [AddrW-1:0]            cos_waddr, cos_raddr;
  logic [SinAW-1:0]            sin_waddr, sin_raddr;
  logic [CoefWidth-1:0]        wr_coef;
  logic [CoefWidth-1:0]        cos_rdata, sin_rdata;
  logic signed [CoefWidth-1:0] cos_val, sin_val;

  logic [6:0]  d_eff;
  logic [7:0]  k_q;
  logic [31:0] phase_q, pk_q;
  logic [SineTableBits-1:0] sidx, cidx;
  logic signed [15:0] cos_rom_q, sin_rom_q;

  logic signed [CoefWidth-1:0] mul_a;
  logic signed [15:0]          mul_b;
  logic signed [ProdW-1:0]     prod_q;
  logic signed [63:0]          acc_q;
  logic signed [63:0]          rnd;
  logic signed [63:0]          quo;
  logic signed [31:0]          series;
  logic                        bad;

  logic     out_valid_q;
  fse_out_t out_q, res_d;

  // Configuration.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q     <= 7'd1;
      inv_period_q <= 32'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEGREE:     degree_q     <= cfg_data_i[6:0];
        CFG_INV_PERIOD: inv_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= in_data_i;
    end
  end

  assign d_eff = (32'(degree_q) > MaxDegree) ? 7'(MaxDegree) : degree_q;
  assign bad   = item_q.index > d_eff;

  // Coefficient writes, saturated to the stored width.
  always_comb begin
    wr_coef = CoefWidth'(item_q.coef_value);
    if (longint'(item_q.coef_value) > CoefHi) begin
      wr_coef = CoefWidth'(CoefHi);
    end else if (longint'(item_q.coef_value) < CoefLo) begin
      wr_coef = CoefWidth'(CoefLo);
    end
  end

  assign cos_we    = cmd_i.wr_en && (item_q.opcode == OP_WR_COS)
                     && (32'(item_q.index) <= MaxDegree);
  assign sin_we    = cmd_i.wr_en && (item_q.opcode == OP_WR_SIN)
                     && (item_q.index != 7'd0) && (32'(item_q.index) <= MaxDegree);
  assign cos_waddr = AddrW'(item_q.index);
  assign sin_waddr = SinAW'(item_q.index - 7'd1);

  always_comb begin
    cos_raddr = AddrW'(k_q);
    sin_raddr = SinAW'(k_q - 8'd1);
    if (cmd_i.rd_item) begin
      cos_raddr = AddrW'(item_q.index);
      sin_raddr = SinAW'(item_q.index - 7'd1);
    end else if (cmd_i.phase_calc) begin
      cos_raddr = '0;
    end
  end

  assign cos_re = cmd_i.rd_item || cmd_i.phase_calc || cmd_i.fetch;
  assign sin_re = cmd_i.rd_item || cmd_i.fetch;

  fse_ram #(
    .DataWidth(CoefWidth),
    .Depth    (MaxDegree + 1),
    .AddrWidth(AddrW)
  ) u_cos_ram (
    .clk_i  (clk_i),
    .we_i   (cos_we),
    .waddr_i(cos_waddr),
    .wdata_i(wr_coef),
    .re_i   (cos_re),
    .raddr_i(cos_raddr),
    .rdata_o(cos_rdata)
  );

  fse_ram #(
    .DataWidth(CoefWidth),
    .Depth    (MaxDegree),
    .AddrWidth(SinAW)
  ) u_sin_ram (
    .clk_i  (clk_i),
    .we_i   (sin_we),
    .waddr_i(sin_waddr),
    .wdata_i(wr_coef),
    .re_i   (sin_re),
    .raddr_i(sin_raddr),
    .rdata_o(sin_rdata)
  );

  // Valid bits stand in for the cleared reset contents of both tables.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_vld_q <= '0;
      sin_vld_q <= '0;
      cos_vrd_q <= 1'b0;
      sin_vrd_q <= 1'b0;
    end else begin
      if (cos_we) begin
        cos_vld_q[cos_waddr] <= 1'b1;
      end
      if (sin_we) begin
        sin_vld_q[sin_waddr] <= 1'b1;
      end
      if (cos_re) begin
        cos_vrd_q <= (32'(cos_raddr) <= MaxDegree) ? cos_vld_q[cos_raddr] : 1'b0;
      end
      if (sin_re) begin
        sin_vrd_q <= (32'(sin_raddr) < MaxDegree) ? sin_vld_q[sin_raddr] : 1'b0;
      end
    end
  end

  assign cos_val = cos_vrd_q ? signed'(cos_rdata) : '0;
  assign sin_val = sin_vrd_q ? signed'(sin_rdata) : '0;

  // Phase and harmonic stepping: harmonic k uses k*phase, built by repeated adds.
  assign sidx = pk_q[31 -: SineTableBits];
  assign cidx = sidx + SineTableBits'(Quarter);

  always_ff @(posedge clk_i) begin
    if (cmd_i.phase_calc) begin
      phase_q <= 32'(item_q.point * inv_period_q);
    end
    if (cmd_i.acc_init) begin
      k_q  <= 8'd1;
      pk_q <= phase_q;
    end else if (cmd_i.fetch) begin
      k_q  <= k_q + 8'd1;
      pk_q <= pk_q + phase_q;
    end
    if (cmd_i.fetch) begin
      cos_rom_q <= rom_val(cidx);
      sin_rom_q <= rom_val(sidx);
    end
  end

  assign mul_a = cmd_i.mul_sin ? sin_val : cos_val;
  assign mul_b = cmd_i.mul_sin ? sin_rom_q : cos_rom_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      prod_q <= '0;
      acc_q  <= 64'(cos_val) <<< 14;
    end else begin
      if (cmd_i.mul_en) begin
        prod_q <= mul_a * mul_b;
      end
      if (cmd_i.acc_add) begin
        acc_q <= acc_q + 64'(prod_q);
      end
    end
  end

  // Round half up to Q16.16, then saturate to 32 bits.
  always_comb begin
    rnd = acc_q + 64'sd16384;
    quo = rnd >>> 15;
    if (quo > 64'sd2147483647) begin
      series = 32'sh7fffffff;
    end else if (quo < -64'sd2147483648) begin
      series = 32'sh80000000;
    end else begin
      series = 32'(quo);
    end
  end

  always_comb begin
    res_d = '0;
    if (cmd_i.res_eval) begin
      res_d.series_value = series;
    end else if (bad) begin
      res_d.bad_index = 1'b1;
    end else begin
      res_d.cos_coef = 32'(cos_val);
      res_d.sin_coef = (item_q.index == 7'd0) ? 32'sd0 : 32'(sin_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.in_op    = in_data_i.opcode;
  assign sts_o.d_zero   = (d_eff == 7'd0);
  assign sts_o.more     = ({1'b0, d_eff} >= k_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

### design/fourier_series_evaluator.sv
// Channel   Signals                                  Direction
// in        in_valid_i / in_ready_o / in_data_i      item into the block
// out       out_valid_o / out_ready_i / out_data_o   result out of the block
// cfg       cfg_valid_i / cfg_ready_o / idx, data    register write, always ready
//
// One item at a time. An evaluate covers D = min(degree, MAX_DEGREE) harmonics: one
// shared multiplier handles the cosine and sine term of each harmonic in turn. The
// result register lets the next item start while a result waits; a stalled output
// holds the block only once its next result is ready. Reset clears the coefficient
// tables at once through per-entry valid bits.
// Top level; depends on fse_pkg, fse_ctrl, fse_dp and fse_ram.
`timescale 1ns / 1ps

module fourier_series_evaluator #(
  parameter int unsigned MaxDegree     = fse_pkg::MAX_DEGREE_DEF,
  parameter int unsigned SineTableBits = fse_pkg::SINE_TABLE_BITS_DEF,
  parameter int unsigned CoefWidth     = fse_pkg::COEF_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fse_pkg::fse_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fse_pkg::fse_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  import fse_pkg::*;

  fse_cmd_t cmd;
  fse_sts_t sts;

  fse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fse_dp #(
    .MaxDegree    (MaxDegree),
    .SineTableBits(SineTableBits),
    .CoefWidth    (CoefWidth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### design/fse_checker.sv
// Port-level checker of the Fourier series evaluator and its bind.
// Depends on fse_pkg and fourier_series_evaluator_assert.svh.
`timescale 1ns / 1ps
`include "fourier_series_evaluator_assert.svh"

module fse_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input fse_pkg::fse_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input fse_pkg::fse_out_t out_data_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic [0:0]        cfg_index_i,
  input logic [31:0]       cfg_data_i
);

  import fse_pkg::*;

  `FSE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `FSE_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o), "stalled result changed")
  `FSE_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "item accepted back to back")
  `FSE_ASSERT(a_result_done, $rose(out_valid_o) |-> in_ready_o, "result shown while item still busy")
  `FSE_ASSERT(a_bad_zero, !(out_valid_o && out_data_o.bad_index) || ((out_data_o.cos_coef == 32'sd0) && (out_data_o.sin_coef == 32'sd0) && (out_data_o.series_value == 32'sd0)), "bad read carries data")

endmodule

bind fourier_series_evaluator fse_checker u_fse_checker (.*);
